### rtl/pbpg_pkg.sv
`default_nettype none

package pbpg_pkg;

  localparam int unsigned LINE_CLOCKS = 228;
  localparam int unsigned X_W = 8;
  localparam int unsigned Y_W = 9;

  localparam logic [X_W-1:0] PF_START = 8'd68;
  localparam logic [X_W-1:0] X_LAST = 8'd227;
  localparam logic [X_W-1:0] HSYNC_X = 8'd66;
  localparam logic [Y_W-1:0] VSYNC_Y = 9'd3;
  localparam logic [Y_W-1:0] VBLANK_BOTTOM_Y = 9'd232;
  localparam int unsigned HALF_BITS = 20;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_BG_ENABLE = 2'd2;

  localparam logic [2:0] REG_PF0 = 3'd0;
  localparam logic [2:0] REG_PF1 = 3'd1;
  localparam logic [2:0] REG_PF2 = 3'd2;
  localparam logic [2:0] REG_PF_COLOUR = 3'd3;
  localparam logic [2:0] REG_BG_COLOUR = 3'd4;
  localparam logic [2:0] REG_CONTROL = 3'd5;

  typedef struct packed {
    logic [7:0] pattern_zero;
    logic [7:0] pattern_one;
    logic [7:0] pattern_two;
    logic       reflect;
  } pf_regs_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam logic [23:0] PALETTE [128] = '{
    {8'd0, 8'd0, 8'd0}, {8'd64, 8'd64, 8'd64},
    {8'd108, 8'd108, 8'd108}, {8'd144, 8'd144, 8'd144},
    {8'd176, 8'd176, 8'd176}, {8'd200, 8'd200, 8'd200},
    {8'd220, 8'd220, 8'd220}, {8'd236, 8'd236, 8'd236},
    {8'd68, 8'd68, 8'd0}, {8'd100, 8'd100, 8'd16},
    {8'd132, 8'd132, 8'd36}, {8'd160, 8'd160, 8'd52},
    {8'd184, 8'd184, 8'd64}, {8'd208, 8'd208, 8'd80},
    {8'd232, 8'd232, 8'd92}, {8'd252, 8'd252, 8'd104},
    {8'd112, 8'd40, 8'd0}, {8'd132, 8'd68, 8'd20},
    {8'd152, 8'd92, 8'd40}, {8'd172, 8'd120, 8'd60},
    {8'd188, 8'd140, 8'd76}, {8'd204, 8'd160, 8'd92},
    {8'd220, 8'd180, 8'd104}, {8'd236, 8'd200, 8'd120},
    {8'd132, 8'd24, 8'd0}, {8'd152, 8'd52, 8'd24},
    {8'd172, 8'd80, 8'd48}, {8'd192, 8'd104, 8'd72},
    {8'd208, 8'd128, 8'd92}, {8'd224, 8'd148, 8'd112},
    {8'd236, 8'd168, 8'd128}, {8'd252, 8'd188, 8'd148},
    {8'd136, 8'd0, 8'd0}, {8'd156, 8'd32, 8'd32},
    {8'd176, 8'd60, 8'd60}, {8'd192, 8'd88, 8'd88},
    {8'd208, 8'd112, 8'd112}, {8'd224, 8'd136, 8'd136},
    {8'd236, 8'd160, 8'd160}, {8'd252, 8'd180, 8'd180},
    {8'd120, 8'd0, 8'd92}, {8'd140, 8'd32, 8'd116},
    {8'd160, 8'd60, 8'd136}, {8'd176, 8'd88, 8'd156},
    {8'd192, 8'd112, 8'd176}, {8'd208, 8'd132, 8'd192},
    {8'd220, 8'd156, 8'd208}, {8'd236, 8'd176, 8'd224},
    {8'd72, 8'd0, 8'd120}, {8'd96, 8'd32, 8'd144},
    {8'd120, 8'd60, 8'd164}, {8'd140, 8'd88, 8'd184},
    {8'd160, 8'd112, 8'd204}, {8'd180, 8'd132, 8'd220},
    {8'd196, 8'd156, 8'd236}, {8'd212, 8'd176, 8'd252},
    {8'd20, 8'd0, 8'd132}, {8'd48, 8'd32, 8'd152},
    {8'd76, 8'd60, 8'd172}, {8'd104, 8'd88, 8'd192},
    {8'd124, 8'd112, 8'd208}, {8'd148, 8'd136, 8'd224},
    {8'd168, 8'd160, 8'd236}, {8'd188, 8'd180, 8'd252},
    {8'd0, 8'd0, 8'd136}, {8'd28, 8'd32, 8'd156},
    {8'd56, 8'd64, 8'd176}, {8'd80, 8'd92, 8'd192},
    {8'd104, 8'd116, 8'd208}, {8'd124, 8'd140, 8'd224},
    {8'd144, 8'd164, 8'd236}, {8'd164, 8'd184, 8'd252},
    {8'd0, 8'd24, 8'd124}, {8'd28, 8'd56, 8'd144},
    {8'd56, 8'd84, 8'd168}, {8'd80, 8'd112, 8'd188},
    {8'd104, 8'd136, 8'd204}, {8'd124, 8'd156, 8'd220},
    {8'd144, 8'd180, 8'd236}, {8'd164, 8'd200, 8'd252},
    {8'd0, 8'd44, 8'd92}, {8'd28, 8'd76, 8'd120},
    {8'd56, 8'd104, 8'd144}, {8'd80, 8'd132, 8'd172},
    {8'd104, 8'd156, 8'd192}, {8'd124, 8'd180, 8'd212},
    {8'd144, 8'd204, 8'd232}, {8'd164, 8'd224, 8'd252},
    {8'd0, 8'd60, 8'd44}, {8'd28, 8'd92, 8'd72},
    {8'd56, 8'd124, 8'd100}, {8'd80, 8'd156, 8'd128},
    {8'd104, 8'd180, 8'd148}, {8'd124, 8'd208, 8'd172},
    {8'd144, 8'd228, 8'd192}, {8'd164, 8'd252, 8'd212},
    {8'd0, 8'd60, 8'd0}, {8'd32, 8'd92, 8'd32},
    {8'd64, 8'd124, 8'd64}, {8'd92, 8'd156, 8'd92},
    {8'd116, 8'd180, 8'd116}, {8'd140, 8'd208, 8'd140},
    {8'd164, 8'd228, 8'd164}, {8'd184, 8'd252, 8'd184},
    {8'd20, 8'd56, 8'd0}, {8'd52, 8'd92, 8'd28},
    {8'd80, 8'd124, 8'd56}, {8'd108, 8'd152, 8'd80},
    {8'd132, 8'd180, 8'd104}, {8'd156, 8'd204, 8'd124},
    {8'd180, 8'd228, 8'd144}, {8'd200, 8'd252, 8'd164},
    {8'd44, 8'd48, 8'd0}, {8'd76, 8'd80, 8'd28},
    {8'd104, 8'd112, 8'd52}, {8'd132, 8'd140, 8'd76},
    {8'd156, 8'd168, 8'd100}, {8'd180, 8'd192, 8'd120},
    {8'd204, 8'd212, 8'd136}, {8'd224, 8'd236, 8'd156},
    {8'd68, 8'd40, 8'd0}, {8'd100, 8'd72, 8'd24},
    {8'd132, 8'd104, 8'd48}, {8'd160, 8'd132, 8'd68},
    {8'd184, 8'd156, 8'd88}, {8'd208, 8'd180, 8'd108},
    {8'd232, 8'd204, 8'd124}, {8'd252, 8'd224, 8'd140}
  };

endpackage

`default_nettype wire

### rtl/pbpg_playfield.sv
`default_nettype none

module pbpg_playfield (
  input  var pbpg_pkg::pf_regs_t regs_i,
  input  wire logic [7:0]        beam_x_i,
  output logic                   pf_bit_o
);

  logic [pbpg_pkg::HALF_BITS-1:0] half_bits;
  logic [7:0]                     offset;
  logic [5:0]                     slot;
  logic [4:0]                     right_slot;
  logic [4:0]                     idx;

  // one half line of playfield, in beam order
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      half_bits[i] = regs_i.pattern_zero[4+i];
    end
    for (int i = 0; i < 8; i++) begin
      half_bits[4+i] = regs_i.pattern_one[7-i];
      half_bits[12+i] = regs_i.pattern_two[i];
    end
  end

  assign offset = beam_x_i - pbpg_pkg::PF_START;
  assign slot = offset[7:2];
  assign right_slot = 5'(slot - 6'(pbpg_pkg::HALF_BITS));

  always_comb begin
    if (slot < 6'(pbpg_pkg::HALF_BITS)) begin
      idx = slot[4:0];
    end else if (regs_i.reflect) begin
      idx = 5'(pbpg_pkg::HALF_BITS - 1) - right_slot;
    end else begin
      idx = right_slot;
    end
  end

  assign pf_bit_o = (beam_x_i >= pbpg_pkg::PF_START) && (beam_x_i <= pbpg_pkg::X_LAST)
                    && half_bits[idx];

endmodule

`default_nettype wire

### rtl/pbpg_palette.sv
`default_nettype none

module pbpg_palette (
  input  wire logic [7:0]  code_i,
  output pbpg_pkg::rgb_t   rgb_o
);

  logic [6:0] entry;

  assign entry = {code_i[7:4], code_i[3:1]};
  assign rgb_o = pbpg_pkg::PALETTE[entry];

endmodule

`default_nettype wire

### rtl/playfield_beam_pixel_generator.sv
// channel | valid     | stall      | payload
// input   | in_valid_i  | in_stall_o  | opcode_i, reg_select_i, write_data_i
// output  | out_valid_o | out_stall_i | pixel_valid_o .. hsync_point_o
//
// one item per cycle while the result is not stalled; results are registered
// items land in an input register, the playfield pick, palette lookup and beam
// step run between it and the result register
// reset clears all playfield registers, the beam and both valid flags
// a stalled result holds the input register; the input stalls only then
`default_nettype none

module playfield_beam_pixel_generator #(
  parameter int unsigned FRAME_LINES = 262
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] opcode_i,
  input  wire logic [2:0] reg_select_i,
  input  wire logic [7:0] write_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            pixel_valid_o,
  output logic [7:0]      pixel_x_o,
  output logic [8:0]      pixel_y_o,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o,
  output logic            vsync_line_o,
  output logic            vblank_top_o,
  output logic            vblank_bottom_o,
  output logic            hsync_point_o
);

  localparam logic [8:0] LAST_LINE = 9'(FRAME_LINES - 1);
  localparam logic [7:0] LAST_CLOCK = 8'(pbpg_pkg::LINE_CLOCKS - 1);

  logic       in_valid_q;
  logic [1:0] opcode_q;
  logic [2:0] reg_select_q;
  logic [7:0] write_data_q;
  logic       advance;

  logic [7:0] pf0_q, pf0_d, pf1_q, pf1_d, pf2_q, pf2_d;
  logic [7:0] pf_colour_q, pf_colour_d, bg_colour_q, bg_colour_d;
  logic [7:0] control_q, control_d;
  logic       bg_enable_q, bg_enable_d;
  logic [7:0] beam_x_q, beam_x_d;
  logic [8:0] beam_y_q, beam_y_d;

  pbpg_pkg::pf_regs_t pf_regs;
  pbpg_pkg::rgb_t     rgb;
  logic               pf_bit;
  logic               drawn;
  logic [7:0]         code;

  logic       out_valid_q;
  logic       pixel_valid_q;
  logic [7:0] pixel_x_q;
  logic [8:0] pixel_y_q;
  logic [7:0] red_q, green_q, blue_q;
  logic       vsync_q, vblank_top_q, vblank_bottom_q, hsync_q;

  assign advance = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      opcode_q <= opcode_i;
      reg_select_q <= reg_select_i;
      write_data_q <= write_data_i;
    end
  end

  assign pf_regs = '{pattern_zero: pf0_q, pattern_one: pf1_q, pattern_two: pf2_q,
                     reflect: control_q[0]};

  pbpg_playfield u_playfield (
    .regs_i   (pf_regs),
    .beam_x_i (beam_x_q),
    .pf_bit_o (pf_bit)
  );

  assign drawn = (opcode_q == pbpg_pkg::OP_TICK) && (pf_bit || bg_enable_q);
  assign code = pf_bit ? pf_colour_q : bg_colour_q;

  pbpg_palette u_palette (
    .code_i (code),
    .rgb_o  (rgb)
  );

  always_comb begin
    pf0_d = pf0_q;
    pf1_d = pf1_q;
    pf2_d = pf2_q;
    pf_colour_d = pf_colour_q;
    bg_colour_d = bg_colour_q;
    control_d = control_q;
    bg_enable_d = bg_enable_q;
    beam_x_d = beam_x_q;
    beam_y_d = beam_y_q;
    unique case (opcode_q)
      pbpg_pkg::OP_TICK: begin
        if (beam_x_q >= LAST_CLOCK) begin
          beam_x_d = '0;
          bg_enable_d = 1'b0;
          beam_y_d = (beam_y_q >= LAST_LINE) ? '0 : beam_y_q + 9'd1;
        end else begin
          beam_x_d = beam_x_q + 8'd1;
        end
      end
      pbpg_pkg::OP_WRITE: begin
        unique case (reg_select_q)
          pbpg_pkg::REG_PF0:       pf0_d = write_data_q;
          pbpg_pkg::REG_PF1:       pf1_d = write_data_q;
          pbpg_pkg::REG_PF2:       pf2_d = write_data_q;
          pbpg_pkg::REG_PF_COLOUR: pf_colour_d = write_data_q;
          pbpg_pkg::REG_BG_COLOUR: bg_colour_d = write_data_q;
          pbpg_pkg::REG_CONTROL:   control_d = write_data_q;
          default: ;
        endcase
      end
      pbpg_pkg::OP_BG_ENABLE: bg_enable_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pf0_q <= '0;
      pf1_q <= '0;
      pf2_q <= '0;
      pf_colour_q <= '0;
      bg_colour_q <= '0;
      control_q <= '0;
      bg_enable_q <= 1'b0;
      beam_x_q <= '0;
      beam_y_q <= '0;
    end else if (in_valid_q && advance) begin
      pf0_q <= pf0_d;
      pf1_q <= pf1_d;
      pf2_q <= pf2_d;
      pf_colour_q <= pf_colour_d;
      bg_colour_q <= bg_colour_d;
      control_q <= control_d;
      bg_enable_q <= bg_enable_d;
      beam_x_q <= beam_x_d;
      beam_y_q <= beam_y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && advance) begin
      pixel_valid_q <= drawn;
      pixel_x_q <= drawn ? beam_x_q : '0;
      pixel_y_q <= drawn ? beam_y_q : '0;
      red_q <= drawn ? rgb.red : '0;
      green_q <= drawn ? rgb.green : '0;
      blue_q <= drawn ? rgb.blue : '0;
      vsync_q <= beam_y_d == pbpg_pkg::VSYNC_Y;
      vblank_top_q <= beam_y_d < pbpg_pkg::VSYNC_Y;
      vblank_bottom_q <= beam_y_d >= pbpg_pkg::VBLANK_BOTTOM_Y;
      hsync_q <= beam_x_d == pbpg_pkg::HSYNC_X;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_valid_o = pixel_valid_q;
  assign pixel_x_o = pixel_x_q;
  assign pixel_y_o = pixel_y_q;
  assign red_o = red_q;
  assign green_o = green_q;
  assign blue_o = blue_q;
  assign vsync_line_o = vsync_q;
  assign vblank_top_o = vblank_top_q;
  assign vblank_bottom_o = vblank_bottom_q;
  assign hsync_point_o = hsync_q;

`ifndef SYNTHESIS
  a_beam_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beam_x_q <= LAST_CLOCK)
    else $error("beam x out of range");

  a_beam_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beam_y_q <= LAST_LINE)
    else $error("beam y out of range");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with no item held");

  a_line_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && advance && opcode_q == pbpg_pkg::OP_TICK && beam_x_q == LAST_CLOCK)
    |=> beam_x_q == '0 && !bg_enable_q)
    else $error("line end did not wrap beam");
`endif

endmodule

`default_nettype wire
